/* design/usplit_pkg.sv */
// ----------------------------------------------------------------------------
// usplit_pkg
// Shared types, codes and helpers for the URI component splitter.
// ----------------------------------------------------------------------------
package usplit_pkg;

	// number of result slots one item can fill
	localparam int unsigned MaxRes = 4;
	localparam int unsigned ResCntW = $clog2(MaxRes + 1);

	// parser phases
	localparam logic [2:0] PH_SCHEME = 3'd0;
	localparam logic [2:0] PH_HOST   = 3'd1;
	localparam logic [2:0] PH_PORT   = 3'd2;
	localparam logic [2:0] PH_PATH   = 3'd3;
	localparam logic [2:0] PH_QUERY  = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	// component tags
	localparam logic [2:0] COMP_SCHEME = 3'd0;
	localparam logic [2:0] COMP_HOST   = 3'd1;
	localparam logic [2:0] COMP_PORT   = 3'd2;
	localparam logic [2:0] COMP_PATH   = 3'd3;
	localparam logic [2:0] COMP_QUERY  = 3'd4;

	// error codes
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_EMPTY      = 2'd1;
	localparam logic [1:0] ERR_END_SCHEME = 2'd2;
	localparam logic [1:0] ERR_BAD_PATH   = 2'd3;

	// percent hold levels in the query
	localparam logic [1:0] PCT_NONE = 2'd0;
	localparam logic [1:0] PCT_ONE  = 2'd1;
	localparam logic [1:0] PCT_TWO  = 2'd2;

	// slash run marker: other bytes seen since the last colon
	localparam logic [1:0] SLASH_OTHER = 2'd3;

	// characters of interest
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_QUEST   = 8'h3F;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_TWO     = 8'h32;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// parser state carried from item to item
	typedef struct packed {
		logic       any_byte_seen;
		logic [1:0] error_code;
		logic [1:0] percent_held;
		logic       prev_dot;
		logic [1:0] slash_count;
		logic       scheme_seen;
		logic [2:0] phase;
	} state_t;

	// one result item
	typedef struct packed {
		logic       last;
		logic [1:0] error;
		logic       field_end;
		logic [2:0] component;
		logic [7:0] out_byte;
		logic       byte_valid;
	} result_t;

	typedef result_t [MaxRes-1:0] result_set_t;

	// build one result
	function automatic result_t mk_res(input logic v, input logic [7:0] b,
		input logic [2:0] comp, input logic fe, input logic [1:0] err,
		input logic lst);
		result_t r;
		r.byte_valid = v;
		r.out_byte   = b;
		r.component  = comp;
		r.field_end  = fe;
		r.error      = err;
		r.last       = lst;
		return r;
	endfunction

endpackage

/* design/uri_component_splitter.sv */
// ----------------------------------------------------------------------------
// uri_component_splitter
// Streaming URI splitter: tags each byte as scheme, host, port, path or
// query, marks component ends and flags malformed URIs.
// ----------------------------------------------------------------------------
// Usage:
//  - input stream s_axis: one URI byte per item in tdata, then one item with
//    tlast high that ends the URI (its tdata is ignored)
//  - output stream m_axis: result items; tdata is the byte, tuser tags it,
//    tlast marks the final result of a URI
//  - an item goes into an input register, the combinational parser step
//    works on it there, and its results land in a four-entry result
//    buffer once the buffer can take them; the first result is offered
//    from the head of that buffer
//  - one input item per cycle while each item gives at most one result and
//    m_axis_tready is high; an item that gives more results holds the input
//    until its last result has left the one-result-per-cycle result buffer
//  - items that give no result advance the parser state but fill no buffer entry
//  - when the receiver stalls, the buffer holds, then the input register
//    fills and s_axis_tready drops; nothing is lost
//  - reset clears the parser state to the scheme phase and empties both
//    the input register and the result buffer
// ----------------------------------------------------------------------------
module uri_component_splitter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] char_in
	input  logic       s_axis_tlast,  // end_of_uri
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic [6:0] m_axis_tuser,  // [0] byte_valid, [3:1] component, [4] field_end, [6:5] error
	output logic       m_axis_tlast   // last
);

	logic                           valid_s1;
	logic [7:0]                     char_s1;
	logic                           end_s1;
	usplit_pkg::state_t             state_q;
	usplit_pkg::state_t             state_nxt;
	usplit_pkg::result_set_t        step_res;
	logic [usplit_pkg::ResCntW-1:0] step_cnt;
	logic                           buf_can_load;
	logic                           xfer;
	usplit_pkg::result_t            head;

	assign xfer          = valid_s1 && buf_can_load;
	assign s_axis_tready = !valid_s1 || xfer;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
		end
	end

	// parser state advances when an item's results enter the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (xfer) begin
			state_q <= state_nxt;
		end
	end

	usplit_step u_step (
		.st         (state_q),
		.char_in    (char_s1),
		.end_of_uri (end_s1),
		.nxt        (state_nxt),
		.res        (step_res),
		.res_cnt    (step_cnt)
	);

	usplit_resbuf u_resbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (xfer),
		.load_res  (step_res),
		.load_cnt  (step_cnt),
		.pop       (m_axis_tready),
		.can_load  (buf_can_load),
		.out_valid (m_axis_tvalid),
		.out_res   (head)
	);

	// output packing
	assign m_axis_tdata = head.out_byte;
	assign m_axis_tuser = {head.error, head.field_end, head.component, head.byte_valid};
	assign m_axis_tlast = head.last;

	// errors only ride on the final result of a URI
	a_err_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && head.error != usplit_pkg::ERR_NONE |-> head.last)
		else $error("error code on a result that is not last");

	// a result never carries a byte and a field end together
	a_byte_or_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(head.byte_valid && head.field_end))
		else $error("byte and field end on one result");

	// an end marker leaves the parser in its reset state
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && end_s1 |=> state_q == '0)
		else $error("parser state not cleared after end marker");

	// a result without a byte carries a zero byte
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !head.byte_valid |-> head.out_byte == 8'h00)
		else $error("nonzero byte on a result without byte");

endmodule

/* design/usplit_step.sv */
// ----------------------------------------------------------------------------
// usplit_step
// Combinational parser step: from the current state and one item, gives the
// list of results and the next state.
// ----------------------------------------------------------------------------
module usplit_step (
	input  usplit_pkg::state_t      st,
	input  logic [7:0]              char_in,
	input  logic                    end_of_uri,
	output usplit_pkg::state_t      nxt,
	output usplit_pkg::result_set_t res,
	output logic [usplit_pkg::ResCntW-1:0] res_cnt
);

	logic [usplit_pkg::ResCntW-1:0] n;
	logic do_host;
	logic slash_held;

	always_comb begin
		nxt     = st;
		res     = '0;
		n       = '0;
		do_host = 1'b0;
		// held slashes are returned only after a nonempty scheme
		slash_held = st.scheme_seen && (st.slash_count == 2'd1 || st.slash_count == 2'd2);

		if (end_of_uri) begin
			// end marker closes the open component (or flags an empty URI or one that ends in the scheme) and resets the parser
			if (!st.any_byte_seen) begin
				res[n[1:0]] = usplit_pkg::mk_res(1'b0, 8'h00, usplit_pkg::COMP_SCHEME,
					1'b0, usplit_pkg::ERR_EMPTY, 1'b1);
				n = n + 1'b1;
			end else begin
				case (st.phase)
					usplit_pkg::PH_SCHEME: begin
						if (slash_held) begin
							res[n[1:0]] = usplit_pkg::mk_res(1'b1, usplit_pkg::CH_SLASH,
								usplit_pkg::COMP_SCHEME, 1'b0, usplit_pkg::ERR_NONE, 1'b0);
							n = n + 1'b1;
							if (st.slash_count == 2'd2) begin
								res[n[1:0]] = usplit_pkg::mk_res(1'b1, usplit_pkg::CH_SLASH,
									usplit_pkg::COMP_SCHEME, 1'b0, usplit_pkg::ERR_NONE, 1'b0);
								n = n + 1'b1;
							end
						end
						res[n[1:0]] = usplit_pkg::mk_res(1'b0, 8'h00, usplit_pkg::COMP_SCHEME,
							1'b0, usplit_pkg::ERR_END_SCHEME, 1'b1);
						n = n + 1'b1;
					end
					usplit_pkg::PH_HOST: begin
						res[n[1:0]] = usplit_pkg::mk_res(1'b0, 8'h00, usplit_pkg::COMP_HOST,
							1'b1, usplit_pkg::ERR_NONE, 1'b1);
						n = n + 1'b1;
					end
					usplit_pkg::PH_PORT: begin
						res[n[1:0]] = usplit_pkg::mk_res(1'b0, 8'h00, usplit_pkg::COMP_PORT,
							1'b1, usplit_pkg::ERR_NONE, 1'b1);
						n = n + 1'b1;
					end
					usplit_pkg::PH_PATH: begin
						res[n[1:0]] = usplit_pkg::mk_res(1'b0, 8'h00, usplit_pkg::COMP_PATH,
							1'b1, st.error_code, 1'b1);
						n = n + 1'b1;
					end
					usplit_pkg::PH_QUERY: begin
						if (st.percent_held != usplit_pkg::PCT_NONE) begin
							res[n[1:0]] = usplit_pkg::mk_res(1'b1, usplit_pkg::CH_PERCENT,
								usplit_pkg::COMP_QUERY, 1'b0, usplit_pkg::ERR_NONE, 1'b0);
							n = n + 1'b1;
						end
						if (st.percent_held == usplit_pkg::PCT_TWO) begin
							res[n[1:0]] = usplit_pkg::mk_res(1'b1, usplit_pkg::CH_TWO,
								usplit_pkg::COMP_QUERY, 1'b0, usplit_pkg::ERR_NONE, 1'b0);
							n = n + 1'b1;
						end
						res[n[1:0]] = usplit_pkg::mk_res(1'b0, 8'h00, usplit_pkg::COMP_QUERY,
							1'b1, usplit_pkg::ERR_NONE, 1'b1);
						n = n + 1'b1;
					end
					default: begin
					end
				endcase
			end
			nxt = '0;
		end else begin
			nxt.any_byte_seen = 1'b1;
			case (st.phase)
				// scheme phase with the slash run tracking
				usplit_pkg::PH_SCHEME: begin
					if (char_in == usplit_pkg::CH_COLON) begin
						if (slash_held) begin
							res[n[1:0]] = usplit_pkg::mk_res(1'b1, usplit_pkg::CH_SLASH,
								usplit_pkg::COMP_SCHEME, 1'b0, usplit_pkg::ERR_NONE, 1'b0);
							n = n + 1'b1;
							if (st.slash_count == 2'd2) begin
								res[n[1:0]] = usplit_pkg::mk_res(1'b1, usplit_pkg::CH_SLASH,
									usplit_pkg::COMP_SCHEME, 1'b0, usplit_pkg::ERR_NONE, 1'b0);
								n = n + 1'b1;
							end
						end
						res[n[1:0]] = usplit_pkg::mk_res(1'b0, 8'h00, usplit_pkg::COMP_SCHEME,
							1'b1, usplit_pkg::ERR_NONE, 1'b0);
						n = n + 1'b1;
						nxt.scheme_seen = (st.slash_count != 2'd0);
						nxt.slash_count = 2'd0;
					end else if (st.scheme_seen && st.slash_count == 2'd2) begin
						do_host = 1'b1;
					end else if (st.scheme_seen && char_in == usplit_pkg::CH_SLASH
						&& st.slash_count < 2'd2) begin
						nxt.slash_count = st.slash_count + 2'd1;
					end else begin
						if (slash_held) begin
							res[n[1:0]] = usplit_pkg::mk_res(1'b1, usplit_pkg::CH_SLASH,
								usplit_pkg::COMP_SCHEME, 1'b0, usplit_pkg::ERR_NONE, 1'b0);
							n = n + 1'b1;
							if (st.slash_count == 2'd2) begin
								res[n[1:0]] = usplit_pkg::mk_res(1'b1, usplit_pkg::CH_SLASH,
									usplit_pkg::COMP_SCHEME, 1'b0, usplit_pkg::ERR_NONE, 1'b0);
								n = n + 1'b1;
							end
						end
						res[n[1:0]] = usplit_pkg::mk_res(1'b1, char_in, usplit_pkg::COMP_SCHEME,
							1'b0, usplit_pkg::ERR_NONE, 1'b0);
						n = n + 1'b1;
						nxt.slash_count = usplit_pkg::SLASH_OTHER;
					end
				end
				usplit_pkg::PH_HOST: begin
					do_host = 1'b1;
				end
				// port runs until a slash
				usplit_pkg::PH_PORT: begin
					if (char_in == usplit_pkg::CH_SLASH) begin
						res[n[1:0]] = usplit_pkg::mk_res(1'b0, 8'h00, usplit_pkg::COMP_PORT,
							1'b1, usplit_pkg::ERR_NONE, 1'b0);
						n = n + 1'b1;
						res[n[1:0]] = usplit_pkg::mk_res(1'b1, usplit_pkg::CH_SLASH,
							usplit_pkg::COMP_PATH, 1'b0, usplit_pkg::ERR_NONE, 1'b0);
						n = n + 1'b1;
						nxt.phase    = usplit_pkg::PH_PATH;
						nxt.prev_dot = 1'b0;
					end else begin
						res[n[1:0]] = usplit_pkg::mk_res(1'b1, char_in, usplit_pkg::COMP_PORT,
							1'b0, usplit_pkg::ERR_NONE, 1'b0);
						n = n + 1'b1;
					end
				end
				// path runs until '?', watching for a double dot
				usplit_pkg::PH_PATH: begin
					if (char_in == usplit_pkg::CH_QUEST) begin
						if (st.error_code == usplit_pkg::ERR_BAD_PATH) begin
							res[n[1:0]] = usplit_pkg::mk_res(1'b0, 8'h00, usplit_pkg::COMP_PATH,
								1'b1, usplit_pkg::ERR_BAD_PATH, 1'b1);
							n = n + 1'b1;
							nxt.phase = usplit_pkg::PH_DONE;
						end else begin
							res[n[1:0]] = usplit_pkg::mk_res(1'b0, 8'h00, usplit_pkg::COMP_PATH,
								1'b1, usplit_pkg::ERR_NONE, 1'b0);
							n = n + 1'b1;
							nxt.phase        = usplit_pkg::PH_QUERY;
							nxt.percent_held = usplit_pkg::PCT_NONE;
						end
					end else begin
						if (char_in == usplit_pkg::CH_DOT && st.prev_dot)
							nxt.error_code = usplit_pkg::ERR_BAD_PATH;
						nxt.prev_dot = (char_in == usplit_pkg::CH_DOT);
						res[n[1:0]] = usplit_pkg::mk_res(1'b1, char_in, usplit_pkg::COMP_PATH,
							1'b0, usplit_pkg::ERR_NONE, 1'b0);
						n = n + 1'b1;
					end
				end
				// query with the %20 decode
				usplit_pkg::PH_QUERY: begin
					if (st.percent_held == usplit_pkg::PCT_NONE) begin
						if (char_in == usplit_pkg::CH_PERCENT) begin
							nxt.percent_held = usplit_pkg::PCT_ONE;
						end else begin
							res[n[1:0]] = usplit_pkg::mk_res(1'b1, char_in,
								usplit_pkg::COMP_QUERY, 1'b0, usplit_pkg::ERR_NONE, 1'b0);
							n = n + 1'b1;
						end
					end else if (st.percent_held == usplit_pkg::PCT_ONE) begin
						if (char_in == usplit_pkg::CH_TWO) begin
							nxt.percent_held = usplit_pkg::PCT_TWO;
						end else begin
							res[n[1:0]] = usplit_pkg::mk_res(1'b1, usplit_pkg::CH_PERCENT,
								usplit_pkg::COMP_QUERY, 1'b0, usplit_pkg::ERR_NONE, 1'b0);
							n = n + 1'b1;
							if (char_in == usplit_pkg::CH_PERCENT) begin
								nxt.percent_held = usplit_pkg::PCT_ONE;
							end else begin
								res[n[1:0]] = usplit_pkg::mk_res(1'b1, char_in,
									usplit_pkg::COMP_QUERY, 1'b0, usplit_pkg::ERR_NONE, 1'b0);
								n = n + 1'b1;
								nxt.percent_held = usplit_pkg::PCT_NONE;
							end
						end
					end else begin
						if (char_in == usplit_pkg::CH_ZERO) begin
							res[n[1:0]] = usplit_pkg::mk_res(1'b1, usplit_pkg::CH_SPACE,
								usplit_pkg::COMP_QUERY, 1'b0, usplit_pkg::ERR_NONE, 1'b0);
							n = n + 1'b1;
							nxt.percent_held = usplit_pkg::PCT_NONE;
						end else begin
							// give back the held "%2" as-is
							res[n[1:0]] = usplit_pkg::mk_res(1'b1, usplit_pkg::CH_PERCENT,
								usplit_pkg::COMP_QUERY, 1'b0, usplit_pkg::ERR_NONE, 1'b0);
							n = n + 1'b1;
							if (st.percent_held == usplit_pkg::PCT_TWO) begin
								res[n[1:0]] = usplit_pkg::mk_res(1'b1, usplit_pkg::CH_TWO,
									usplit_pkg::COMP_QUERY, 1'b0, usplit_pkg::ERR_NONE, 1'b0);
								n = n + 1'b1;
							end
							if (char_in == usplit_pkg::CH_PERCENT) begin
								nxt.percent_held = usplit_pkg::PCT_ONE;
							end else begin
								res[n[1:0]] = usplit_pkg::mk_res(1'b1, char_in,
									usplit_pkg::COMP_QUERY, 1'b0, usplit_pkg::ERR_NONE, 1'b0);
								n = n + 1'b1;
								nxt.percent_held = usplit_pkg::PCT_NONE;
							end
						end
					end
				end
				default: begin
				end
			endcase

			// host rules, also for the first byte after "//"
			if (do_host) begin
				nxt.phase = usplit_pkg::PH_HOST;
				if (char_in == usplit_pkg::CH_COLON) begin
					res[n[1:0]] = usplit_pkg::mk_res(1'b0, 8'h00, usplit_pkg::COMP_HOST,
						1'b1, usplit_pkg::ERR_NONE, 1'b0);
					n = n + 1'b1;
					nxt.phase = usplit_pkg::PH_PORT;
				end else if (char_in == usplit_pkg::CH_SLASH) begin
					res[n[1:0]] = usplit_pkg::mk_res(1'b0, 8'h00, usplit_pkg::COMP_HOST,
						1'b1, usplit_pkg::ERR_NONE, 1'b0);
					n = n + 1'b1;
					res[n[1:0]] = usplit_pkg::mk_res(1'b1, usplit_pkg::CH_SLASH,
						usplit_pkg::COMP_PATH, 1'b0, usplit_pkg::ERR_NONE, 1'b0);
					n = n + 1'b1;
					nxt.phase    = usplit_pkg::PH_PATH;
					nxt.prev_dot = 1'b0;
				end else begin
					res[n[1:0]] = usplit_pkg::mk_res(1'b1, char_in, usplit_pkg::COMP_HOST,
						1'b0, usplit_pkg::ERR_NONE, 1'b0);
					n = n + 1'b1;
				end
			end
		end
		res_cnt = n;
	end

endmodule

/* design/usplit_resbuf.sv */
// ----------------------------------------------------------------------------
// usplit_resbuf
// Result buffer: takes the whole result list of one item and hands the
// results out one per cycle while pop is high, head first.
// ----------------------------------------------------------------------------
module usplit_resbuf (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  usplit_pkg::result_set_t        load_res,
	input  logic [usplit_pkg::ResCntW-1:0] load_cnt,
	input  logic                           pop,
	output logic                           can_load,
	output logic                           out_valid,
	output usplit_pkg::result_t            out_res
);

	logic [usplit_pkg::ResCntW-1:0] cnt_q;
	usplit_pkg::result_set_t        ent_q;
	logic                           take;

	assign out_valid = (cnt_q != '0);
	assign out_res   = ent_q[0];
	assign take      = pop && out_valid;
	// a new list may enter once the last held result leaves
	assign can_load  = (cnt_q == '0) ||
		(cnt_q == {{(usplit_pkg::ResCntW-1){1'b0}}, 1'b1} && take);

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= load_cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// entries shift toward the head
	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= load_res;
		end else if (take) begin
			for (int i = 0; i < usplit_pkg::MaxRes - 1; i++)
				ent_q[i] <= ent_q[i+1];
			ent_q[usplit_pkg::MaxRes-1] <= '0;
		end
	end

endmodule
